// ===== hdl/isort_pkg.sv =====
// shared types and constants for the insertion sorter
// no dependencies; used by every file of the block
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CAPACITY_DEFAULT = 32;

    // input word
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         frame_end;
    } item_t;

    // output word
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         final_res;
        logic                         overflowed;
    } result_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic                         insert;
        logic                         shift;
        logic signed [DATA_WIDTH-1:0] new_value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/isort_cell.sv =====
// one cell of the sorting chain: holds one value and its valid bit
// depends on isort_pkg
`timescale 1ns / 1ps
`default_nettype none

module isort_cell (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire isort_pkg::cell_ctrl_t              ctrl,
    input  wire                                     left_gt,
    input  wire                                     left_valid,
    input  wire signed [isort_pkg::DATA_WIDTH-1:0]  left_value,
    input  wire                                     right_valid,
    input  wire signed [isort_pkg::DATA_WIDTH-1:0]  right_value,
    output logic                                    gt,
    output logic                                    valid,
    output logic signed [isort_pkg::DATA_WIDTH-1:0] value
);

    logic                                    valid_reg;
    logic                                    valid_next;
    logic signed [isort_pkg::DATA_WIDTH-1:0] value_reg;
    logic signed [isort_pkg::DATA_WIDTH-1:0] value_next;

    // empty cells count as greater than anything
    assign gt = !valid_reg || (value_reg > ctrl.new_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = right_valid;
            value_next = right_value;
        end
        else if (ctrl.insert && gt)
        begin
            valid_next = valid_reg | left_valid;
            value_next = left_gt ? left_value : ctrl.new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hdl/insertion_sorter.sv =====
// top level of the insertion sorter: chain of isort_cell plus frame control
// depends on isort_pkg and isort_cell
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel item / item_valid / item_ready carries one signed value per word,
//   with frame_end set on the last word of a frame
// - output channel res / res_valid / res_ready returns the frame in ascending
//   order, stable for equal values; final_res marks the last word, overflowed
//   is set on every word of a frame that lost words to a full store
// - one input word per cycle while a frame is loading: the new value is
//   broadcast to every cell and each cell decides in the same cycle whether
//   to keep, take the new value, or take its left neighbor's value
// - after the frame_end word, the chain drains through cell 0: the first
//   result shows in the cycle after that word, then one result per cycle
//   while res_ready is high
// - item_ready is low while draining; the next frame starts the cycle after
//   the final word is taken
// - a stall on res_ready simply holds the chain; cell 0 is the output register
// - words arriving while CAPACITY values are held are dropped
// - reset clears the fill count, the overflow flag, the drain flag and all
//   cell valid bits; cell values are not reset

module insertion_sorter #(
    parameter int CAPACITY = isort_pkg::CAPACITY_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire isort_pkg::item_t  item,
    input  wire                    item_valid,
    output logic                   item_ready,
    output isort_pkg::result_t     res,
    output logic                   res_valid,
    input  wire                    res_ready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = isort_pkg::DATA_WIDTH;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          drain_reg;
    logic          drain_next;

    logic item_take;
    logic res_take;
    logic full;

    isort_pkg::cell_ctrl_t ctrl;

    logic                 cell_gt    [CAPACITY];
    logic                 cell_valid [CAPACITY];
    logic signed [DW-1:0] cell_value [CAPACITY];

    assign item_ready = !drain_reg;
    assign item_take  = item_valid && item_ready;
    assign res_valid  = drain_reg;
    assign res_take   = res_valid && res_ready;
    assign full       = (count_reg == CW'(CAPACITY));

    // broadcast to the chain
    assign ctrl.insert    = item_take && !full;
    assign ctrl.shift     = res_take;
    assign ctrl.new_value = item.value;

    // sorting chain, cell 0 holds the smallest value
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                 l_gt;
            logic                 l_valid;
            logic signed [DW-1:0] l_value;
            logic                 r_valid;
            logic signed [DW-1:0] r_value;

            if (gi == 0)
            begin : g_first
                assign l_gt    = 1'b0;
                assign l_valid = 1'b1;
                assign l_value = item.value;
            end
            else
            begin : g_inner_l
                assign l_gt    = cell_gt[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign r_valid = 1'b0;
                assign r_value = cell_value[gi];
            end
            else
            begin : g_inner_r
                assign r_valid = cell_valid[gi+1];
                assign r_value = cell_value[gi+1];
            end

            isort_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_gt     (l_gt),
                .left_valid  (l_valid),
                .left_value  (l_value),
                .right_valid (r_valid),
                .right_value (r_value),
                .gt          (cell_gt[gi]),
                .valid       (cell_valid[gi]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    // output word: value straight from cell 0, flags from the frame control
    assign res.sorted_value = cell_value[0];
    assign res.final_res    = (count_reg == CW'(1));
    assign res.overflowed   = ovf_reg;

    // frame control
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        drain_next = drain_reg;
        if (item_take)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
            if (item.frame_end)
            begin
                drain_next = 1'b1;
            end
        end
        if (res_take)
        begin
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                drain_next = 1'b0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            drain_reg <= drain_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/isort_checker.sv =====
// port-level checks for the insertion sorter, bound to the top level
// depends on isort_pkg and insertion_sorter
`timescale 1ns / 1ps
`default_nettype none

module isort_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     item_ready,
    input wire isort_pkg::result_t res,
    input wire                     res_valid,
    input wire                     res_ready
);

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // loading and draining never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && res_valid))
        else $error("input ready while draining");

    // results leave in ascending order within a frame
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.final_res |=>
            res_valid && ($signed(res.sorted_value) >= $signed($past(res.sorted_value))))
        else $error("results out of order");

    // overflow flag is the same on every word of a frame
    a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.final_res |=>
            res_valid && (res.overflowed == $past(res.overflowed)))
        else $error("overflow flag changed within a frame");

    // after the final word the block returns to loading
    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res.final_res |=> !res_valid && item_ready)
        else $error("drain continued after final word");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_ready (item_ready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for insertion_sorter: directed frames, then random frames
// depends on isort_pkg and insertion_sorter; the expected words come from a local sort model
`timescale 1ns / 1ps

module tb;

    localparam int DATA_WIDTH   = isort_pkg::DATA_WIDTH;
    localparam int CAPACITY     = isort_pkg::CAPACITY_DEFAULT;
    localparam int RANDOM_WORDS = 290;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 120;
    localparam int DRAIN_WAIT   = 2 * CAPACITY + 16;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // one row of the directed stimulus; want is only used when typed is set
    typedef struct {
        isort_pkg::item_t   word;
        bit                 typed;
        isort_pkg::result_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    isort_pkg::item_t   item;
    logic               item_valid;
    logic               item_ready;
    isort_pkg::result_t res;
    logic               res_valid;
    logic               res_ready;

    // sort model state: values held for the current frame, in arrival-stable order
    logic signed [DATA_WIDTH-1:0] held_vals[$];
    bit                           drop_seen;

    // sorted words still owed by the block, oldest first
    isort_pkg::result_t pending_sorted[$];
    stim_row_t          directed_rows[$];

    int  mismatches;
    int  words_in;
    bit  steady;

    insertion_sorter #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #200000;
        $display("FAIL insertion_sorter");
        $finish;
    end

    // insert one accepted word into the model; a frame_end word flushes the frame
    function automatic void absorb_word(input isort_pkg::item_t w);
        int                 pos;
        isort_pkg::result_t r;
        if (held_vals.size() >= CAPACITY)
        begin
            // store full: word dropped, frame gets flagged
            drop_seen = 1'b1;
        end
        else
        begin
            // stable: land after every held value that is not greater
            pos = held_vals.size();
            while (pos > 0 && held_vals[pos-1] > w.value)
                pos--;
            held_vals.insert(pos, w.value);
        end
        if (w.frame_end)
        begin
            for (int i = 0; i < held_vals.size(); i++)
            begin
                r.sorted_value = held_vals[i];
                r.final_res    = (i == held_vals.size() - 1);
                r.overflowed   = drop_seen;
                pending_sorted.push_back(r);
            end
            held_vals.delete();
            drop_seen = 1'b0;
        end
    endfunction

    function automatic void add_row(input logic signed [DATA_WIDTH-1:0] v, input bit fe,
            input bit typed, input logic signed [DATA_WIDTH-1:0] want_v,
            input bit want_final, input bit want_ovf);
        stim_row_t r;
        r.word.value        = v;
        r.word.frame_end    = fe;
        r.typed             = typed;
        r.want.sorted_value = want_v;
        r.want.final_res    = want_final;
        r.want.overflowed   = want_ovf;
        directed_rows.push_back(r);
    endfunction

    // values lean on the extremes and on a narrow band so ties are common
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        int tiny;
        tiny = $urandom_range(8);
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            4:       return tiny - 4;
            default: return $urandom;
        endcase
    endfunction

    // mostly short frames, some filling the store exactly, some spilling over it
    function automatic int pick_frame_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return $urandom_range(8, 1);
        else if (roll < 75)
            return $urandom_range(CAPACITY - 1, 9);
        else if (roll < 85)
            return CAPACITY;
        else
            return $urandom_range(CAPACITY + 8, CAPACITY + 1);
    endfunction

    // offer one word, with a random gap first, and wait for the handshake
    task automatic send_word(input isort_pkg::item_t w);
        int gaps;
        gaps = 0;
        while (!steady && $urandom_range(99) < IDLE_PCT)
            gaps++;
        if (gaps > 0)
        begin
            item_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        words_in++;
        absorb_word(w);
    endtask

    // receiver: checks every word taken, idles at random, stalls once for a long stretch
    initial
    begin : receiver
        int                 hold_left;
        bit                 hold_done;
        isort_pkg::result_t want;
        res_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
            begin
                if (pending_sorted.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected word: value %0d final %0b ovf %0b",
                                 res.sorted_value, res.final_res, res.overflowed);
                end
                else
                begin
                    want = pending_sorted.pop_front();
                    if (res.sorted_value !== want.sorted_value ||
                        res.final_res !== want.final_res ||
                        res.overflowed !== want.overflowed)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: want %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.sorted_value, want.final_res, want.overflowed,
                                     res.sorted_value, res.final_res, res.overflowed);
                    end
                end
            end
            // long hold-off as a drain starts, so the chain backs up into the input
            if (!hold_done && res_valid && words_in >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (steady)
                res_ready <= 1'b1;
            else
                res_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // sender: directed rows, then random frames, then drain and verdict
    initial
    begin : sender
        isort_pkg::item_t w;
        int               len;
        int               random_words;
        int               random_frames;
        rst_n        = 1'b0;
        item         = '0;
        item_valid   = 1'b0;
        drop_seen    = 1'b0;
        mismatches   = 0;
        words_in     = 0;
        steady       = 1'b0;
        random_words = 0;
        random_frames = 0;

        // single-word frames come straight back: extremes, zero, minus one
        add_row(VAL_MAX, 1'b1, 1'b1, VAL_MAX, 1'b1, 1'b0);
        add_row(VAL_MIN, 1'b1, 1'b1, VAL_MIN, 1'b1, 1'b0);
        add_row('0,      1'b1, 1'b1, '0,      1'b1, 1'b0);
        add_row('1,      1'b1, 1'b1, '1,      1'b1, 1'b0);
        // mixed extremes in one frame
        add_row(VAL_MAX, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(VAL_MIN, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row('0,      1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row('1,      1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(1,       1'b1, 1'b0, '0, 1'b0, 1'b0);
        // ties around a sign flip
        add_row(7,  1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(-7, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(7,  1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(7,  1'b1, 1'b0, '0, 1'b0, 1'b0);
        // descending input, every word after the first shifts the chain
        add_row(3, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(2, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(0, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        // already ascending
        add_row(-2, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(-1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(5,  1'b1, 1'b0, '0, 1'b0, 1'b0);
        // alternating bit patterns
        add_row(32'h5555_5555, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(32'hAAAA_AAAA, 1'b1, 1'b0, '0, 1'b0, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            send_word(directed_rows[k].word);
            // typed rows are single-word frames: their word is the last one owed
            if (directed_rows[k].typed)
                pending_sorted[pending_sorted.size()-1] = directed_rows[k].want;
        end

        // first a frame one past full (the frame_end word itself is dropped),
        // then an exactly full one, then random lengths
        while (random_words < RANDOM_WORDS)
        begin
            if (random_frames == 0)
                len = CAPACITY + 1;
            else if (random_frames == 1)
                len = CAPACITY;
            else
                len = pick_frame_len();
            for (int i = 0; i < len; i++)
            begin
                // a stretch with no idling on either side
                steady = (random_words >= 100 && random_words < 180);
                w.value     = pick_value();
                w.frame_end = (i == len - 1);
                send_word(w);
                random_words++;
            end
            random_frames++;
        end
        steady     = 1'b0;
        item_valid <= 1'b0;

        while (pending_sorted.size() != 0)
            @(posedge clk);
        // give any stray word time to show up
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("PASS insertion_sorter");
        else
            $display("FAIL insertion_sorter");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/isort_pkg.sv
hdl/isort_cell.sv
hdl/insertion_sorter.sv
hdl/isort_checker.sv
tb/sv/tb.sv
